// ===== sv/hhs_pkg.sv =====
`timescale 1ns / 1ps

package hhs_pkg;

  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned RISK_W    = 11;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] HOLD_MAX   = 10'd1023;
  localparam logic [LEVEL_W-1:0] INDEX_FULL = 10'd1000;

  typedef enum logic [1:0] {
    LVL_SAFE   = 2'd0,
    LVL_WARN   = 2'd1,
    LVL_DANGER = 2'd2,
    LVL_FAULT  = 2'd3
  } level_t;

  typedef enum logic [2:0] {
    RSN_NONE     = 3'd0,
    RSN_STARTUP  = 3'd1,
    RSN_SENSOR   = 3'd2,
    RSN_OVERTEMP = 3'd3,
    RSN_UNDERVOLT = 3'd4,
    RSN_DATA_LOST = 3'd5
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAFE_TO_WARN_LEVEL    = 3'd0,
    CFG_WARN_TO_DANGER_LEVEL  = 3'd1,
    CFG_WARN_TO_SAFE_LEVEL    = 3'd2,
    CFG_DANGER_TO_WARN_LEVEL  = 3'd3,
    CFG_SAFE_TO_WARN_FRAMES   = 3'd4,
    CFG_WARN_TO_DANGER_FRAMES = 3'd5,
    CFG_WARN_TO_SAFE_FRAMES   = 3'd6,
    CFG_DANGER_TO_WARN_FRAMES = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] safe_to_warn_level;
    logic [LEVEL_W-1:0] warn_to_danger_level;
    logic [LEVEL_W-1:0] warn_to_safe_level;
    logic [LEVEL_W-1:0] danger_to_warn_level;
    logic [LEVEL_W-1:0] safe_to_warn_frames;
    logic [LEVEL_W-1:0] warn_to_danger_frames;
    logic [LEVEL_W-1:0] warn_to_safe_frames;
    logic [LEVEL_W-1:0] danger_to_warn_frames;
  } cfg_t;

  typedef struct packed {
    logic              startup_timed_out;
    logic [AGE_W-1:0]  data_age_ticks;
    logic              undervolt_flag;
    logic              overtemp_flag;
    logic              sensor_fault_flag;
    logic [RISK_W-1:0] drop_risk_tenths;
    logic [RISK_W-1:0] temp_risk_tenths;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] health_index;
    logic               alarm_changed;
    reason_t            fault_reason;
    level_t             alert_level;
  } result_t;

endpackage

// ===== sv/hhs_cfg_regs.sv =====
`timescale 1ns / 1ps

module hhs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hhs_pkg::LEVEL_W-1:0]    cfg_data,
  output hhs_pkg::cfg_t                  cfg
);

  hhs_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safe_to_warn_level    <= 10'd800;
      cfg_r.warn_to_danger_level  <= 10'd400;
      cfg_r.warn_to_safe_level    <= 10'd840;
      cfg_r.danger_to_warn_level  <= 10'd450;
      cfg_r.safe_to_warn_frames   <= 10'd10;
      cfg_r.warn_to_danger_frames <= 10'd5;
      cfg_r.warn_to_safe_frames   <= 10'd50;
      cfg_r.danger_to_warn_frames <= 10'd25;
    end else if (cfg_valid) begin
      case (hhs_pkg::cfg_idx_t'(cfg_index))
        hhs_pkg::CFG_SAFE_TO_WARN_LEVEL:    cfg_r.safe_to_warn_level    <= cfg_data;
        hhs_pkg::CFG_WARN_TO_DANGER_LEVEL:  cfg_r.warn_to_danger_level  <= cfg_data;
        hhs_pkg::CFG_WARN_TO_SAFE_LEVEL:    cfg_r.warn_to_safe_level    <= cfg_data;
        hhs_pkg::CFG_DANGER_TO_WARN_LEVEL:  cfg_r.danger_to_warn_level  <= cfg_data;
        hhs_pkg::CFG_SAFE_TO_WARN_FRAMES:   cfg_r.safe_to_warn_frames   <= cfg_data;
        hhs_pkg::CFG_WARN_TO_DANGER_FRAMES: cfg_r.warn_to_danger_frames <= cfg_data;
        hhs_pkg::CFG_WARN_TO_SAFE_FRAMES:   cfg_r.warn_to_safe_frames   <= cfg_data;
        hhs_pkg::CFG_DANGER_TO_WARN_FRAMES: cfg_r.danger_to_warn_frames <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/hhs_eval.sv =====
`timescale 1ns / 1ps

module hhs_eval #(
  parameter int unsigned STALE_LIMIT_TICKS = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  hhs_pkg::item_t   item,
  input  hhs_pkg::cfg_t    cfg,
  output hhs_pkg::result_t res
);

  localparam logic [hhs_pkg::AGE_W-1:0] STALE_LIMIT = hhs_pkg::AGE_W'(STALE_LIMIT_TICKS);

  hhs_pkg::level_t               level_r, level_nxt;
  hhs_pkg::level_t               pending_r, pending_nxt;
  logic [hhs_pkg::LEVEL_W-1:0]   hold_r, hold_nxt;
  logic                          first_r, first_nxt;
  logic                          locked_r, locked_nxt;
  hhs_pkg::reason_t              reason_r, reason_nxt;
  hhs_pkg::level_t               published_r, published_nxt;

  logic signed [hhs_pkg::RISK_W:0] sum;
  logic [hhs_pkg::LEVEL_W-1:0]     sum_clamped;
  logic [hhs_pkg::LEVEL_W-1:0]     hi;
  logic                            rule_hit;
  hhs_pkg::level_t                 rule_target;
  logic [hhs_pkg::LEVEL_W-1:0]     rule_frames;
  logic [hhs_pkg::LEVEL_W-1:0]     hold_step;
  hhs_pkg::level_t                 alarm;
  logic                            changed;

  always_comb begin
    sum = $signed({item.temp_risk_tenths[hhs_pkg::RISK_W-1], item.temp_risk_tenths})
        + $signed({item.drop_risk_tenths[hhs_pkg::RISK_W-1], item.drop_risk_tenths});
    if (sum[hhs_pkg::RISK_W]) begin
      sum_clamped = '0;
    end else if (sum > $signed({2'b00, hhs_pkg::INDEX_FULL})) begin
      sum_clamped = hhs_pkg::INDEX_FULL;
    end else begin
      sum_clamped = sum[hhs_pkg::LEVEL_W-1:0];
    end
    hi = hhs_pkg::INDEX_FULL - sum_clamped;

    level_nxt     = level_r;
    pending_nxt   = pending_r;
    hold_nxt      = hold_r;
    first_nxt     = 1'b0;
    locked_nxt    = locked_r;
    reason_nxt    = reason_r;
    published_nxt = published_r;
    rule_hit      = 1'b0;
    rule_target   = hhs_pkg::LVL_SAFE;
    rule_frames   = '0;
    hold_step     = '0;
    changed       = 1'b0;

    if (first_r) begin
      if (hi < cfg.warn_to_danger_level) begin
        level_nxt = hhs_pkg::LVL_DANGER;
      end else if (hi < cfg.safe_to_warn_level) begin
        level_nxt = hhs_pkg::LVL_WARN;
      end else begin
        level_nxt = hhs_pkg::LVL_SAFE;
      end
      if (item.startup_timed_out && !locked_r) begin
        locked_nxt = 1'b1;
        reason_nxt = hhs_pkg::RSN_STARTUP;
      end
      alarm         = locked_nxt ? hhs_pkg::LVL_FAULT : level_nxt;
      published_nxt = level_nxt;
      hold_nxt      = '0;
      pending_nxt   = level_nxt;
    end else begin
      case (level_r)
        hhs_pkg::LVL_SAFE: begin
          rule_hit    = hi < cfg.safe_to_warn_level;
          rule_target = hhs_pkg::LVL_WARN;
          rule_frames = cfg.safe_to_warn_frames;
        end
        hhs_pkg::LVL_WARN: begin
          if (hi < cfg.warn_to_danger_level) begin
            rule_hit    = 1'b1;
            rule_target = hhs_pkg::LVL_DANGER;
            rule_frames = cfg.warn_to_danger_frames;
          end else begin
            rule_hit    = hi > cfg.warn_to_safe_level;
            rule_target = hhs_pkg::LVL_SAFE;
            rule_frames = cfg.warn_to_safe_frames;
          end
        end
        hhs_pkg::LVL_DANGER: begin
          rule_hit    = hi > cfg.danger_to_warn_level;
          rule_target = hhs_pkg::LVL_WARN;
          rule_frames = cfg.danger_to_warn_frames;
        end
        default: rule_hit = 1'b0;
      endcase

      if (rule_hit) begin
        if (pending_r == rule_target) begin
          hold_step = (hold_r == hhs_pkg::HOLD_MAX) ? hold_r : hold_r + 10'd1;
        end else begin
          hold_step = 10'd1;
        end
        pending_nxt = rule_target;
        if (hold_step >= rule_frames) begin
          level_nxt = rule_target;
          hold_nxt  = '0;
        end else begin
          hold_nxt = hold_step;
        end
      end else begin
        hold_nxt    = '0;
        pending_nxt = level_r;
      end

      if (!locked_r) begin
        if (item.sensor_fault_flag) begin
          locked_nxt = 1'b1;
          reason_nxt = hhs_pkg::RSN_SENSOR;
        end else if (item.overtemp_flag) begin
          locked_nxt = 1'b1;
          reason_nxt = hhs_pkg::RSN_OVERTEMP;
        end else if (item.undervolt_flag) begin
          locked_nxt = 1'b1;
          reason_nxt = hhs_pkg::RSN_UNDERVOLT;
        end else if (item.data_age_ticks > STALE_LIMIT) begin
          locked_nxt = 1'b1;
          reason_nxt = hhs_pkg::RSN_DATA_LOST;
        end
      end

      alarm = locked_nxt ? hhs_pkg::LVL_FAULT : level_nxt;
      if (alarm != published_r) begin
        changed       = 1'b1;
        published_nxt = alarm;
      end
    end

    res.alert_level   = alarm;
    res.fault_reason  = reason_nxt;
    res.alarm_changed = changed;
    res.health_index  = hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= hhs_pkg::LVL_SAFE;
      pending_r   <= hhs_pkg::LVL_SAFE;
      hold_r      <= '0;
      first_r     <= 1'b1;
      locked_r    <= 1'b0;
      reason_r    <= hhs_pkg::RSN_NONE;
      published_r <= hhs_pkg::LVL_SAFE;
    end else if (step) begin
      level_r     <= level_nxt;
      pending_r   <= pending_nxt;
      hold_r      <= hold_nxt;
      first_r     <= first_nxt;
      locked_r    <= locked_nxt;
      reason_r    <= reason_nxt;
      published_r <= published_nxt;
    end
  end

endmodule

// ===== sv/health_hysteresis_supervisor_top.sv =====
`timescale 1ns / 1ps

// Health supervisor with hysteresis: each input item is one monitoring frame and gives
// exactly one result item. An item is captured in an input register, evaluated
// combinationally against the hysteresis state and the fault latch, and written to an
// output register, so the block takes one item per clock; it stalls only while the
// output register holds a result that has not been taken.
// Configuration writes are always accepted and should be made while no item is in flight.
module health_hysteresis_supervisor_top #(
  parameter int unsigned STALE_LIMIT_TICKS = 100
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // s_axis: [10:0] temp_risk_tenths, [21:11] drop_risk_tenths, [22] sensor_fault_flag,
  // [23] overtemp_flag, [24] undervolt_flag, [40:25] data_age_ticks,
  // [41] startup_timed_out, [47:42] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hhs_pkg::IN_DATA_W-1:0]   in_tdata,
  // m_axis: [1:0] alert_level, [4:2] fault_reason, [5] alarm_changed, [15:6] health_index
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hhs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hhs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hhs_pkg::LEVEL_W-1:0]     cfg_data
);

  hhs_pkg::cfg_t    cfg;
  hhs_pkg::item_t   item_r;
  hhs_pkg::result_t res;
  hhs_pkg::result_t res_r;
  logic             item_valid_r;
  logic             out_valid_r;
  logic             out_free;
  logic             step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = item_valid_r && out_free;
  assign in_tready = !item_valid_r || out_free;

  hhs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hhs_eval #(
    .STALE_LIMIT_TICKS (STALE_LIMIT_TICKS)
  ) u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= hhs_pkg::item_t'(in_tdata[$bits(hhs_pkg::item_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

`ifndef NO_ASSERTIONS
  a_fault_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == hhs_pkg::LVL_FAULT) |-> (out_tdata[4:2] != hhs_pkg::RSN_NONE))
    else $error("hard fault alarm without a latched reason");

  a_reason_forces_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[4:2] != hhs_pkg::RSN_NONE) |-> (out_tdata[1:0] == hhs_pkg::LVL_FAULT))
    else $error("latched reason without hard fault alarm");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:6] <= hhs_pkg::INDEX_FULL))
    else $error("health index above full scale");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");
`endif

endmodule
